### rtl/core/assert_macros.svh
// Assertion macros shared by the sponge RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KSR_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define KSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`define KSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define KSR_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define KSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define KSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/ksr_pkg.sv
// Types, constants and helpers for the reduced-round sponge.
package ksr_pkg;

    localparam int STATE_BITS = 1600;
    localparam int NUM_LANES = 25;
    localparam int LANE_W = 64;
    localparam int STATE_BYTES = STATE_BITS / 8;
    localparam int MAX_ROUNDS = 24;
    localparam int DEF_MAX_OUTPUT_BYTES = 64;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] LFSR_INIT = 8'h01;
    localparam logic [7:0] LFSR_POLY = 8'h71;
    localparam logic [7:0] LFSR_MSB = 8'h80;

    localparam logic [10:0] RATE_RST = 11'd1024;
    localparam logic [10:0] CAP_RST = 11'd576;
    localparam logic [4:0] ROUNDS_RST = 5'd24;
    localparam logic [6:0] OUTLEN_RST = 7'd16;

    localparam logic [5:0] RHO [NUM_LANES] = '{
        6'd0, 6'd1, 6'd62, 6'd28, 6'd27,
        6'd36, 6'd44, 6'd6, 6'd55, 6'd20,
        6'd3, 6'd10, 6'd43, 6'd25, 6'd39,
        6'd41, 6'd45, 6'd15, 6'd21, 6'd8,
        6'd18, 6'd2, 6'd61, 6'd56, 6'd14
    };

    localparam int PI_DST [NUM_LANES] = '{
        0, 10, 20, 5, 15,
        16, 1, 11, 21, 6,
        7, 17, 2, 12, 22,
        23, 8, 18, 3, 13,
        14, 24, 9, 19, 4
    };

    localparam int XP1 [5] = '{1, 2, 3, 4, 0};
    localparam int XP2 [5] = '{2, 3, 4, 0, 1};
    localparam int XM1 [5] = '{4, 0, 1, 2, 3};
    localparam int IOTA_POS [7] = '{0, 1, 3, 7, 15, 31, 63};

    typedef logic [STATE_BITS-1:0] t_state_vec;
    typedef logic [LANE_W-1:0] t_lane;

    typedef struct packed {
        logic [10:0] rate_bits;
        logic [10:0] capacity_bits;
        logic [4:0]  round_count;
        logic [6:0]  output_bytes;
    } t_cfg;

    typedef enum logic [1:0] {
        REG_RATE   = 2'd0,
        REG_CAP    = 2'd1,
        REG_ROUNDS = 2'd2,
        REG_OUTLEN = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PERM,
        S_OUT
    } t_fsm;

    function automatic t_lane rotl64(input t_lane v, input logic [5:0] n);
        if (n == 6'd0) begin
            return v;
        end
        return (v << n) | (v >> (7'd64 - {1'b0, n}));
    endfunction

endpackage

### rtl/core/keccak_sponge_reduced_rounds.sv
// Top level of the byte-fed Keccak-f[1600] sponge with a configurable round count.
//
// Channel  | Direction | Payload
// s_axis   | in        | tdata = data_byte, tuser = has_byte, tlast = is_last
// m_axis   | out       | tdata = tag_byte, tuser = error, tlast = last_byte
// apb      | in/out    | rate_bits, capacity_bits, round_count, output_bytes at 0, 4, 8, 12
//
// A full rate block is followed by its rounds, run one at a time through a single round
// unit, and no byte is taken while they run.
// After the last word the squeeze gives one byte per cycle while the sink is ready, except
// at each rate block boundary, where the rounds run again.
// Reset is synchronous and clears the state, the fill position and the settings to defaults.
// Results sit in an output register, so the next word is taken while the final one waits.
module keccak_sponge_reduced_rounds #(
    parameter int MAX_OUTPUT_BYTES = ksr_pkg::DEF_MAX_OUTPUT_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    input  logic                           s_axis_tuser,  // [0] has_byte
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [7:0] tag_byte
    output logic                           m_axis_tuser,  // [0] error
    output logic                           m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ksr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ksr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ksr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ksr_pkg::*;

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(MAX_OUTPUT_BYTES + 1);
    localparam logic [6:0] MAX_OB = 7'(MAX_OUTPUT_BYTES);

    t_cfg       cfg;
    t_fsm       r_state, n_state;
    t_state_vec r_lanes, n_lanes;
    t_state_vec round_lanes;
    logic [7:0] r_fill, n_fill;
    logic [4:0] r_round, n_round;
    logic [7:0] r_lfsr, n_lfsr;
    logic [7:0] round_lfsr;
    logic       r_last, n_last;
    logic [7:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic       r_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_err, n_out_err;
    logic       r_out_last, n_out_last;
    logic       out_load;
    logic       out_free;
    logic       cfg_ok;
    logic [7:0] rate_bytes;
    logic [4:0] rounds;
    logic [CNT_W-1:0] out_len;

    ksr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ksr_round u_round (
        .i_state (r_lanes),
        .i_lfsr  (r_lfsr),
        .o_state (round_lanes),
        .o_lfsr  (round_lfsr)
    );

    assign cfg_ok = ({1'b0, cfg.rate_bits} + {1'b0, cfg.capacity_bits} == 12'(STATE_BITS))
                    && (cfg.rate_bits[2:0] == 3'd0) && (cfg.rate_bits != 11'd0);
    assign rate_bytes = cfg.rate_bits[10:3];
    assign rounds  = (cfg.round_count > 5'(MAX_ROUNDS)) ? 5'(MAX_ROUNDS) : cfg.round_count;
    assign out_len = (cfg.output_bytes > MAX_OB) ? CNT_W'(MAX_OB) : CNT_W'(cfg.output_bytes);
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lanes     <= '0;
            r_fill      <= '0;
            r_round     <= '0;
            r_lfsr      <= LFSR_INIT;
            r_last      <= 1'b0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lanes <= n_lanes;
            r_fill  <= n_fill;
            r_round <= n_round;
            r_lfsr  <= n_lfsr;
            r_last  <= n_last;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state    = r_state;
        n_lanes    = r_lanes;
        n_fill     = r_fill;
        n_round    = r_round;
        n_lfsr     = r_lfsr;
        n_last     = r_last;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        out_load   = 1'b0;
        n_out_byte = r_out_byte;
        n_out_err  = r_out_err;
        n_out_last = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_last  = s_axis_tlast;
                    n_pos   = '0;
                    n_cnt   = '0;
                    n_round = '0;
                    n_lfsr  = LFSR_INIT;
                    if (s_axis_tlast) begin
                        n_state = S_OUT;
                    end
                    if (cfg_ok && s_axis_tuser) begin
                        n_lanes[{r_fill, 3'b000} +: 8] =
                            r_lanes[{r_fill, 3'b000} +: 8] ^ s_axis_tdata;
                        if ({1'b0, r_fill} + 9'd1 >= {1'b0, rate_bytes}) begin
                            n_fill = '0;
                            if (rounds != 5'd0) begin
                                n_state = S_PERM;
                            end
                        end else begin
                            n_fill = r_fill + 8'd1;
                        end
                    end
                end
            end
            S_PERM: begin
                n_lanes = round_lanes;
                n_lfsr  = round_lfsr;
                n_round = r_round + 5'd1;
                if (r_round == rounds - 5'd1) begin
                    n_state = r_last ? S_OUT : S_IDLE;
                end
            end
            S_OUT: begin
                if (!cfg_ok) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        n_out_byte = 8'd0;
                        n_out_err  = 1'b1;
                        n_out_last = 1'b1;
                        n_lanes    = '0;
                        n_fill     = '0;
                        n_state    = S_IDLE;
                    end
                end else if (out_len == '0) begin
                    n_lanes = '0;
                    n_fill  = '0;
                    n_state = S_IDLE;
                end else if (r_pos >= rate_bytes) begin
                    n_pos   = '0;
                    n_round = '0;
                    n_lfsr  = LFSR_INIT;
                    if (rounds != 5'd0) begin
                        n_state = S_PERM;
                    end
                end else if (out_free) begin
                    out_load   = 1'b1;
                    n_out_byte = r_lanes[{r_pos, 3'b000} +: 8];
                    n_out_err  = 1'b0;
                    n_out_last = (r_cnt + CNT_W'(1) == out_len);
                    n_pos      = r_pos + 8'd1;
                    n_cnt      = r_cnt + CNT_W'(1);
                    if (r_cnt + CNT_W'(1) == out_len) begin
                        n_lanes = '0;
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `KSR_ASSERT_ALWAYS(a_fill_range, i_clk, i_rst_n, r_fill < 8'(STATE_BYTES), "fill beyond state")
    `KSR_ASSERT_IMPL(a_err_word, i_clk, i_rst_n, r_out_valid && r_out_err, r_out_last && (r_out_byte == 8'd0), "bad error word")
    `KSR_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, out_load && n_out_last, (r_fill == 8'd0) && (r_state == S_IDLE), "state not cleared after last word")

endmodule

### rtl/core/ksr_round.sv
// One Keccak-f[1600] round with its iota constant taken from the round LFSR.
module ksr_round (
    input  ksr_pkg::t_state_vec i_state,
    input  logic [7:0]          i_lfsr,
    output ksr_pkg::t_state_vec o_state,
    output logic [7:0]          o_lfsr
);
    import ksr_pkg::*;

    t_lane a  [NUM_LANES];
    t_lane th [NUM_LANES];
    t_lane b  [NUM_LANES];
    t_lane ch [NUM_LANES];
    t_lane c  [5];
    t_lane d  [5];
    t_lane rc;
    logic [7:0] lfsr_v;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            a[i] = i_state[LANE_W*i +: LANE_W];
        end
        for (int x = 0; x < 5; x++) begin
            c[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
        end
        for (int x = 0; x < 5; x++) begin
            d[x] = c[XM1[x]] ^ rotl64(c[XP1[x]], 6'd1);
        end
        for (int i = 0; i < NUM_LANES; i++) begin
            th[i] = a[i] ^ d[i % 5];
        end
        for (int i = 0; i < NUM_LANES; i++) begin
            b[PI_DST[i]] = rotl64(th[i], RHO[i]);
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                ch[x + 5*y] = b[x + 5*y] ^ (~b[XP1[x] + 5*y] & b[XP2[x] + 5*y]);
            end
        end
        rc = '0;
        lfsr_v = i_lfsr;
        for (int j = 0; j < 7; j++) begin
            if (lfsr_v[0]) begin
                rc[IOTA_POS[j]] = 1'b1;
            end
            lfsr_v = (lfsr_v << 1) ^ (((lfsr_v & LFSR_MSB) != 8'h00) ? LFSR_POLY : 8'h00);
        end
        ch[0] = ch[0] ^ rc;
        for (int i = 0; i < NUM_LANES; i++) begin
            o_state[LANE_W*i +: LANE_W] = ch[i];
        end
        o_lfsr = lfsr_v;
    end

endmodule

### rtl/core/ksr_cfg.sv
// APB register file holding the sponge settings.
module ksr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ksr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ksr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ksr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output ksr_pkg::t_cfg                  o_cfg
);
    import ksr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_bits     <= RATE_RST;
            r_cfg.capacity_bits <= CAP_RST;
            r_cfg.round_count   <= ROUNDS_RST;
            r_cfg.output_bytes  <= OUTLEN_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RATE:   r_cfg.rate_bits     <= pwdata[10:0];
                REG_CAP:    r_cfg.capacity_bits <= pwdata[10:0];
                REG_ROUNDS: r_cfg.round_count   <= pwdata[4:0];
                REG_OUTLEN: r_cfg.output_bytes  <= pwdata[6:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RATE:   prdata = {21'd0, r_cfg.rate_bits};
            REG_CAP:    prdata = {21'd0, r_cfg.capacity_bits};
            REG_ROUNDS: prdata = {27'd0, r_cfg.round_count};
            REG_OUTLEN: prdata = {25'd0, r_cfg.output_bytes};
        endcase
    end

endmodule
